/* hw/rtl/ctf_pkg.sv */
// Package for the complementary tilt filter: widths, register indexes,
// sequencer states, the CORDIC angle table and small fixed-point helpers.
// No dependencies.
package ctf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN = 24;
	localparam int CNT_W = 5;          // holds any step count up to TAB_LEN
	localparam int XY_W = 36;          // CORDIC x/y datapath
	localparam int Z_W = 26;           // CORDIC angle accumulator
	localparam int ANG_W = 25;         // angles in 1/65536 degree
	localparam int PA_W = 26;          // shared multiplier operand A
	localparam int PB_W = 18;          // shared multiplier operand B
	localparam int PROD_W = PA_W + PB_W;
	localparam int CFG_IDX_W = 8;

	localparam logic signed [ANG_W-1:0] ROLL_LIMIT = 25'sd11796480;
	localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 25'sd5898240;
	localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;

	localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_X_OFS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_OFS = 8'd3;

	localparam logic [15:0] GAIN_RESET = 16'd64225;
	localparam logic [15:0] RATE_RESET = 16'd1023;

	// atan(2^-i) in 1/65536 degree
	localparam logic [21:0] ATAN_TAB [TAB_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROLL,
		ST_PITCH,
		ST_FUSE,
		ST_WRITE
	} state_t;

	// clamp a 29-bit value to +-lim
	function automatic logic signed [ANG_W-1:0] clamp_ang(
		input logic signed [28:0] v,
		input logic signed [ANG_W-1:0] lim
	);
		logic signed [28:0] l29;
		l29 = 29'(lim);
		if (v > l29)
			return lim;
		else if (v < -l29)
			return -lim;
		else
			return v[ANG_W-1:0];
	endfunction

	// 1/65536 degree to 1/256 degree, round half up
	function automatic logic signed [17:0] to_out(input logic signed [ANG_W-1:0] v);
		logic signed [ANG_W:0] s;
		s = (ANG_W+1)'(v) + (ANG_W+1)'(128);
		return 18'(s >>> 8);
	endfunction

endpackage

/* hw/rtl/ctf_isqrt.sv */
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on ctf_pkg.
module ctf_isqrt
	import ctf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic [15:0] root,
	output logic        done
);

	logic [31:0] n_q;
	logic [31:0] r_q;
	logic [3:0]  bit_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] b;
	logic [32:0] rb;

	assign b = 32'd1 << {bit_q, 1'b0};
	assign rb = {1'b0, r_q} + {1'b0, b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= 4'd15;
			end else if (run_q) begin
				bit_q <= bit_q - 4'd1;
				if (bit_q == 4'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
		end else if (run_q) begin
			if ({1'b0, n_q} >= rb) begin
				n_q <= n_q - rb[31:0];
				r_q <= (r_q >> 1) + b;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign root = r_q[15:0];
	assign done = done_q;

endmodule

/* hw/rtl/ctf_cordic.sv */
// Iterative CORDIC vectoring unit: atan2(y, x) in 1/65536 degree, one
// micro-rotation per cycle. Depends on ctf_pkg (angle table, widths).
module ctf_cordic
	import ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [16:0]    y_in,
	input  logic signed [16:0]    x_in,
	output logic signed [Z_W-1:0] angle,
	output logic                  done
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [CNT_W-1:0]       i_q;
	logic                   run_q;
	logic                   done_q;

	logic signed [XY_W-1:0] xs, ys, x0, y0, dx, dy;
	logic signed [Z_W-1:0]  z0, tab;

	// quadrant pre-rotation for the left half plane
	always_comb begin
		xs = XY_W'(x_in);
		ys = XY_W'(y_in);
		x0 = xs;
		y0 = ys;
		z0 = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x0 = ys;
				y0 = -xs;
				z0 = Z_QUARTER;
			end else begin
				x0 = -ys;
				y0 = xs;
				z0 = -Z_QUARTER;
			end
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign tab = Z_W'(ATAN_TAB[i_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (x_in == 0 && y_in == 0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				i_q <= i_q + CNT_W'(1);
				if (i_q == LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0 <<< 14;
			y_q <= y0 <<< 14;
			z_q <= z0;
		end else if (run_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	assign angle = z_q;
	assign done = done_q;

endmodule

/* hw/rtl/complementary_tilt_filter.sv */
// Complementary roll/pitch tilt filter, top level: sequencer, shared
// multiplier and fusion state. Depends on ctf_pkg, ctf_isqrt, ctf_cordic.
//
// Usage: one item on the input channel is a raw IMU sample (accel x/y/z,
// gyro x/y). An item is taken when in_valid is high and in_stall is low.
// The block stalls its input for the whole computation of an item:
// squares on the shared multiplier, the square root running beside the
// roll CORDIC, then the pitch CORDIC on the same unit, fusion on the
// multiplier (skipped for the first item after reset) and the load of
// the result register. One result item follows each input item on the
// output channel, taken when out_valid is high and out_stall is low.
// A finished result sits in the output register; the next input item is
// accepted and worked on while it waits, and only the final load waits
// for the register to free up.
// Configuration writes (cfg_valid, always ready) change gain, rate scale
// and gyro offsets; indexes past the list are ignored.
// Reset clears the registers to their defaults, zeroes the fused angles and
// marks the filter unseeded: the first item after reset loads the fused
// angles straight from the accelerometer angles.
module complementary_tilt_filter
	import ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	input  logic signed [15:0]   gyro_x,
	input  logic signed [15:0]   gyro_y,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [16:0]   roll_angle,
	output logic signed [16:0]   pitch_angle,
	output logic signed [16:0]   accel_roll_angle,
	output logic signed [15:0]   accel_pitch_angle,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// configuration registers
	logic [15:0]        gain_q, rate_q;
	logic signed [15:0] gx_ofs_q, gy_ofs_q;

	// sequencer
	state_t     state_q, state_d;
	logic [2:0] k_q;
	logic       seeded_q;
	logic       roll_ok_q, mag_ok_q;

	// captured sample
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [16:0] gx_q, gy_q;

	// datapath
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [ANG_W-1:0]  step_r_q, step_p_q;
	logic signed [ANG_W-1:0]  acc_roll_q, acc_pitch_q;
	logic signed [ANG_W-1:0]  fr_q, fp_q;
	logic [15:0]              mag_q;

	// shared multiplier operands
	logic signed [PA_W-1:0]   op_a;
	logic signed [PB_W-1:0]   op_b;
	logic signed [PROD_W-1:0] mult;
	logic signed [PB_W-1:0]   gain_s, gain_c;
	logic signed [PROD_W:0]   fuse_sum;
	logic signed [ANG_W-1:0]  fuse_val;

	// unit handshakes
	logic                  sq_start, cd_start;
	logic signed [16:0]    cd_y, cd_x;
	logic signed [Z_W-1:0] cd_angle;
	logic                  cd_done, sq_done;
	logic [15:0]           sq_root;
	logic                  roll_ready, mag_ready;
	logic signed [ANG_W-1:0] roll_clamped, pitch_clamped;

	logic in_acc, out_free;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;

	assign gain_s = PB_W'({2'b00, gain_q});
	assign gain_c = PB_W'(65536) - gain_s;

	// fusion rounding: (sum + 0.5) >> 16, then saturate at +-180 degrees
	assign fuse_sum = (PROD_W+1)'(acc_q) + (PROD_W+1)'(prod_q) + (PROD_W+1)'(32768);
	assign fuse_val = clamp_ang(29'(fuse_sum >>> 16), ROLL_LIMIT);

	assign roll_clamped = clamp_ang(29'(cd_angle), ROLL_LIMIT);
	assign pitch_clamped = clamp_ang(29'(cd_angle), PITCH_LIMIT);

	assign roll_ready = roll_ok_q || cd_done;
	assign mag_ready = mag_ok_q || sq_done;

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_SQ: begin
				if (k_q == 3'd0) begin
					op_a = PA_W'(ay_q);
					op_b = PB_W'(ay_q);
				end else begin
					op_a = PA_W'(az_q);
					op_b = PB_W'(az_q);
				end
			end
			ST_FUSE: begin
				case (k_q)
					3'd0: begin
						op_a = PA_W'(gx_q);
						op_b = PB_W'({2'b00, rate_q});
					end
					3'd1: begin
						op_a = PA_W'(gy_q);
						op_b = PB_W'({2'b00, rate_q});
					end
					3'd2: begin
						op_a = PA_W'(fr_q) + PA_W'(step_r_q);
						op_b = gain_s;
					end
					3'd3: begin
						op_a = PA_W'(acc_roll_q);
						op_b = gain_c;
					end
					3'd4: begin
						op_a = PA_W'(fp_q) + PA_W'(step_p_q);
						op_b = gain_s;
					end
					default: begin
						op_a = PA_W'(acc_pitch_q);
						op_b = gain_c;
					end
				endcase
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mult = PROD_W'(op_a) * PROD_W'(op_b);

	// next state and unit starts
	always_comb begin
		state_d = state_q;
		sq_start = 1'b0;
		cd_start = 1'b0;
		cd_y = 17'(ay_q);
		cd_x = 17'(az_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = ST_SQ;
			end
			ST_SQ: begin
				if (k_q == 3'd2) begin
					sq_start = 1'b1;
					cd_start = 1'b1;
					state_d = ST_ROLL;
				end
			end
			ST_ROLL: begin
				cd_y = 17'(ax_q);
				cd_x = mag_ready ? {1'b0, (sq_done ? sq_root : mag_q)} : 17'sd0;
				if (roll_ready && mag_ready) begin
					cd_start = 1'b1;
					state_d = ST_PITCH;
				end
			end
			ST_PITCH: begin
				if (cd_done)
					state_d = seeded_q ? ST_FUSE : ST_WRITE;
			end
			ST_FUSE: begin
				if (k_q == 3'd6)
					state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			seeded_q <= 1'b0;
			roll_ok_q <= 1'b0;
			mag_ok_q <= 1'b0;
			out_valid <= 1'b0;
			gain_q <= GAIN_RESET;
			rate_q <= RATE_RESET;
			gx_ofs_q <= '0;
			gy_ofs_q <= '0;
			fr_q <= '0;
			fp_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= (state_d != state_q) ? 3'd0 : k_q + 3'd1;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BLEND_GAIN: gain_q <= cfg_data;
					REG_RATE_SCALE: rate_q <= cfg_data;
					REG_GYRO_X_OFS: gx_ofs_q <= cfg_data;
					REG_GYRO_Y_OFS: gy_ofs_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_SQ) begin
				roll_ok_q <= 1'b0;
				mag_ok_q <= 1'b0;
			end else if (state_q == ST_ROLL) begin
				if (cd_done)
					roll_ok_q <= 1'b1;
				if (sq_done)
					mag_ok_q <= 1'b1;
			end

			// first item seeds, later items fuse
			if (state_q == ST_PITCH && cd_done && !seeded_q) begin
				fr_q <= acc_roll_q;
				fp_q <= -pitch_clamped;
				seeded_q <= 1'b1;
			end
			if (state_q == ST_FUSE && k_q == 3'd4)
				fr_q <= fuse_val;
			if (state_q == ST_FUSE && k_q == 3'd6)
				fp_q <= fuse_val;

			if (state_q == ST_WRITE && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gx_q <= 17'(gyro_x) - 17'(gx_ofs_q);
			gy_q <= 17'(gyro_y) - 17'(gy_ofs_q);
		end

		prod_q <= mult;
		if ((state_q == ST_SQ && k_q == 3'd1) ||
			(state_q == ST_FUSE && (k_q == 3'd3 || k_q == 3'd5)))
			acc_q <= prod_q;
		if (state_q == ST_FUSE && k_q == 3'd1)
			step_r_q <= ANG_W'(prod_q >>> 8);
		if (state_q == ST_FUSE && k_q == 3'd2)
			step_p_q <= ANG_W'(prod_q >>> 8);

		if (state_q == ST_ROLL && cd_done)
			acc_roll_q <= roll_clamped;
		if (state_q == ST_ROLL && sq_done)
			mag_q <= sq_root;
		if (state_q == ST_PITCH && cd_done)
			acc_pitch_q <= -pitch_clamped;

		if (state_q == ST_WRITE && out_free) begin
			roll_angle <= 17'(to_out(fr_q));
			pitch_angle <= 17'(to_out(fp_q));
			accel_roll_angle <= 17'(to_out(acc_roll_q));
			accel_pitch_angle <= 16'(to_out(acc_pitch_q));
		end
	end

	ctf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (32'(acc_q) + 32'(prod_q)),
		.root     (sq_root),
		.done     (sq_done)
	);

	ctf_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.y_in   (cd_y),
		.x_in   (cd_x),
		.angle  (cd_angle),
		.done   (cd_done)
	);

endmodule
